// ===== src/atd_pkg.sv =====
// Shared types, constants and register codes for the AFSK tone detector.
// No dependencies; every other file in src refers to this package by scoped names.
package atd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int MAX_WINDOW    = 64;
    localparam int STATE_BITS    = 40;
    localparam int G_BITS        = 30;
    localparam int COEFF_BITS    = 16;
    localparam int COEFF_FRAC    = 14;
    localparam int WLEN_BITS     = 7;
    localparam int RATE_BITS     = 18;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 18;
    localparam int MAG_BITS      = 64;
    localparam int MID_DEPTH     = 2;
    localparam int OUT_DEPTH     = 2;

    localparam logic [COEFF_BITS-1:0] MARK_COEFF_RST    = 16'd31171;
    localparam logic [COEFF_BITS-1:0] SPACE_COEFF_RST   = 16'd32290;
    localparam logic [WLEN_BITS-1:0]  WINDOW_LENGTH_RST = 7'd36;
    localparam logic [RATE_BITS-1:0]  SAMPLE_RATE_RST   = 18'd44100;
    localparam logic [RATE_BITS-1:0]  BAUD_RATE_RST     = 18'd1200;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_MARK_COEFF    = 3'd0,
        REG_SPACE_COEFF   = 3'd1,
        REG_WINDOW_LENGTH = 3'd2,
        REG_SAMPLE_RATE   = 3'd3,
        REG_BAUD_RATE     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first;
    } t_in_word;

    typedef struct packed {
        logic bit_res;
        logic tone;
    } t_out_word;

    // Control that travels with each entry of the queue between front and back.
    typedef struct packed {
        logic restart;
        logic has_res;
    } t_mid_ctl;

    typedef struct packed {
        logic [COEFF_BITS-1:0] mark_coeff;
        logic [COEFF_BITS-1:0] space_coeff;
        logic [WLEN_BITS-1:0]  window_length;
        logic [RATE_BITS-1:0]  sample_rate;
        logic [RATE_BITS-1:0]  baud_rate;
    } t_cfg;

endpackage

// ===== src/atd_fifo.sv =====
// Small register queue with full and empty flags, used between the stages.
// Depends on atd_pkg for its default depth.
module atd_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = atd_pkg::MID_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [CNT_BITS-1:0] r_count;
    logic                wr_en;
    logic                rd_en;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= (r_wptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (rd_en) begin
                r_rptr <= (r_rptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/atd_front.sv =====
// Front end: sample intake, symbol timing, window control and both Goertzel filters.
// Depends on atd_pkg; feeds finished windows and restarts to the middle queue.
module atd_front #(
    parameter int STATE_BITS = atd_pkg::STATE_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  atd_pkg::t_cfg             i_cfg,
    input  logic                      i_rate_wr,
    input  logic                      i_push,
    output logic                      o_full,
    input  atd_pkg::t_in_word         i_word,
    output logic                      o_mid_push,
    input  logic                      i_mid_full,
    output atd_pkg::t_mid_ctl         o_mid_ctl,
    output logic [4*STATE_BITS-1:0]   o_mid_state
);

    localparam int SB       = atd_pkg::SAMPLE_BITS;
    localparam int CB       = atd_pkg::COEFF_BITS;
    localparam int RB       = atd_pkg::RATE_BITS;
    localparam int WB       = atd_pkg::WLEN_BITS;
    localparam int LO_BITS  = STATE_BITS / 2;
    localparam int HI_BITS  = STATE_BITS - LO_BITS;
    localparam int PLO_W    = CB + LO_BITS + 1;
    localparam int PHI_W    = CB + HI_BITS;
    localparam int PROD_W   = CB + STATE_BITS;
    localparam int ASH_W    = PROD_W - atd_pkg::COEFF_FRAC;
    localparam int SUM_W    = STATE_BITS + 4;
    localparam int MCNT_W   = $clog2(RB);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PHASE,
        ST_LO,
        ST_HI,
        ST_SUM,
        ST_UPD,
        ST_PUSH
    } t_state;

    t_state                  r_state;
    logic signed [SB-1:0]    r_x;
    logic                    r_restart;
    logic                    r_has_res;
    logic                    r_dirty;
    logic [RB-1:0]           r_phase;
    logic [RB-1:0]           r_step;
    logic [RB-1:0]           r_rp;
    logic [RB-1:0]           r_rb;
    logic [RB-1:0]           r_dp;
    logic [RB-1:0]           r_db;
    logic [MCNT_W-1:0]       r_mcnt;
    logic [WB-1:0]           r_wcnt;
    logic                    r_in_win;
    logic signed [STATE_BITS-1:0] r_s1  [2];
    logic signed [STATE_BITS-1:0] r_s2  [2];
    logic signed [PLO_W-1:0]      r_plo [2];
    logic signed [PHI_W-1:0]      r_phi [2];
    logic signed [PROD_W-1:0]     r_acc [2];

    logic [RB-1:0]           sr_eff;
    logic [RB-1:0]           br_eff;
    logic [WB-1:0]           wl_eff;
    logic [RB-1:0]           ph_in;
    logic [RB:0]             t_p;
    logic [RB:0]             t_b;
    logic [RB-1:0]           n_rp;
    logic [RB-1:0]           n_rb;
    logic [RB:0]             adv;
    logic [RB-1:0]           n_phase;
    logic                    start;
    logic [WB-1:0]           cnt_inc;
    logic                    done;
    logic                    accept;
    logic signed [SB+7:0]    x_sh;
    logic signed [CB-1:0]         coeff   [2];
    logic signed [PLO_W-1:0]      prod_lo [2];
    logic signed [PHI_W-1:0]      prod_hi [2];
    logic signed [PROD_W-1:0]     acc_sum [2];
    logic signed [ASH_W-1:0]      acc_sh  [2];
    logic signed [SUM_W-1:0]      fsum    [2];
    logic signed [STATE_BITS-1:0] n_s0    [2];

    assign sr_eff = (i_cfg.sample_rate == '0) ? RB'(1) : i_cfg.sample_rate;
    assign br_eff = (i_cfg.baud_rate == '0) ? RB'(1) : i_cfg.baud_rate;

    always_comb begin
        if (i_cfg.window_length == '0) begin
            wl_eff = WB'(1);
        end else if ({1'b0, i_cfg.window_length} > 8'(atd_pkg::MAX_WINDOW)) begin
            wl_eff = WB'(atd_pkg::MAX_WINDOW);
        end else begin
            wl_eff = i_cfg.window_length;
        end
    end

    assign ph_in = i_word.first ? '0 : r_phase;

    // One remainder bit per cycle for both the phase and the step reduction.
    assign t_p  = {r_rp, r_dp[RB-1]};
    assign t_b  = {r_rb, r_db[RB-1]};
    assign n_rp = (t_p >= {1'b0, sr_eff}) ? RB'(t_p - {1'b0, sr_eff}) : t_p[RB-1:0];
    assign n_rb = (t_b >= {1'b0, sr_eff}) ? RB'(t_b - {1'b0, sr_eff}) : t_b[RB-1:0];

    assign start   = (r_phase < br_eff);
    assign adv     = {1'b0, r_phase} + {1'b0, sr_eff - r_step};
    assign n_phase = (adv >= {1'b0, sr_eff}) ? RB'(adv - {1'b0, sr_eff}) : adv[RB-1:0];

    assign cnt_inc = r_wcnt + 1'b1;
    assign done    = (cnt_inc >= wl_eff);

    assign accept = i_push && !o_full;
    assign o_full = (r_state != ST_IDLE);
    assign x_sh   = {r_x, 8'b0};

    assign coeff[0] = $signed(i_cfg.mark_coeff);
    assign coeff[1] = $signed(i_cfg.space_coeff);

    for (genvar l = 0; l < 2; l++) begin : g_lane
        assign prod_lo[l] = coeff[l] * $signed({1'b0, r_s1[l][LO_BITS-1:0]});
        assign prod_hi[l] = coeff[l] * $signed(r_s1[l][STATE_BITS-1:LO_BITS]);
        assign acc_sum[l] = $signed({r_phi[l], {LO_BITS{1'b0}}}) + PROD_W'(r_plo[l]);
        assign acc_sh[l]  = r_acc[l][PROD_W-1:atd_pkg::COEFF_FRAC];
        assign fsum[l]    = SUM_W'(x_sh) + SUM_W'(acc_sh[l]) - SUM_W'(r_s2[l]);

        always_comb begin
            if ((&fsum[l][SUM_W-1:STATE_BITS-1]) || !(|fsum[l][SUM_W-1:STATE_BITS-1])) begin
                n_s0[l] = fsum[l][STATE_BITS-1:0];
            end else if (fsum[l][SUM_W-1]) begin
                n_s0[l] = {1'b1, {(STATE_BITS-1){1'b0}}};
            end else begin
                n_s0[l] = {1'b0, {(STATE_BITS-1){1'b1}}};
            end
        end
    end

    assign o_mid_push  = (r_state == ST_PUSH) && !i_mid_full;
    assign o_mid_ctl   = '{restart: r_restart, has_res: r_has_res};
    assign o_mid_state = {r_s1[0], r_s2[0], r_s1[1], r_s2[1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_restart <= 1'b0;
            r_has_res <= 1'b0;
            r_dirty   <= 1'b1;
            r_phase   <= '0;
            r_step    <= '0;
            r_mcnt    <= '0;
            r_wcnt    <= '0;
            r_in_win  <= 1'b1;
            for (int l = 0; l < 2; l++) begin
                r_s1[l] <= '0;
                r_s2[l] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_x       <= i_word.sample;
                        r_restart <= i_word.first;
                        r_has_res <= 1'b0;
                        r_phase   <= ph_in;
                        if (r_dirty) begin
                            r_rp    <= '0;
                            r_rb    <= '0;
                            r_dp    <= ph_in;
                            r_db    <= br_eff;
                            r_mcnt  <= '0;
                            r_state <= ST_MOD;
                        end else begin
                            r_state <= ST_PHASE;
                        end
                    end
                end
                ST_MOD: begin
                    r_rp   <= n_rp;
                    r_rb   <= n_rb;
                    r_dp   <= r_dp << 1;
                    r_db   <= r_db << 1;
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == MCNT_W'(RB - 1)) begin
                        r_phase <= n_rp;
                        r_step  <= n_rb;
                        r_dirty <= 1'b0;
                        r_state <= ST_PHASE;
                    end
                end
                ST_PHASE: begin
                    r_phase <= n_phase;
                    if (start) begin
                        for (int l = 0; l < 2; l++) begin
                            r_s1[l] <= '0;
                            r_s2[l] <= '0;
                        end
                        r_wcnt   <= '0;
                        r_in_win <= 1'b1;
                        r_state  <= ST_LO;
                    end else if (r_in_win) begin
                        r_state <= ST_LO;
                    end else if (r_restart) begin
                        r_state <= ST_PUSH;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_LO: begin
                    for (int l = 0; l < 2; l++) begin
                        r_plo[l] <= prod_lo[l];
                    end
                    r_state <= ST_HI;
                end
                ST_HI: begin
                    for (int l = 0; l < 2; l++) begin
                        r_phi[l] <= prod_hi[l];
                    end
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    for (int l = 0; l < 2; l++) begin
                        r_acc[l] <= acc_sum[l];
                    end
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    for (int l = 0; l < 2; l++) begin
                        r_s2[l] <= r_s1[l];
                        r_s1[l] <= n_s0[l];
                    end
                    r_wcnt <= cnt_inc;
                    if (done) begin
                        r_has_res <= 1'b1;
                        r_in_win  <= 1'b0;
                        r_state   <= ST_PUSH;
                    end else if (r_restart) begin
                        r_state <= ST_PUSH;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_PUSH: begin
                    if (!i_mid_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (i_rate_wr) begin
                r_dirty <= 1'b1;
            end
        end
    end

endmodule

// ===== src/atd_back.sv =====
// Back end: squared magnitudes of both filters, tone decision and NRZI bit.
// Depends on atd_pkg; drains the middle queue and fills the result queue.
module atd_back #(
    parameter int STATE_BITS = atd_pkg::STATE_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  atd_pkg::t_cfg           i_cfg,
    input  logic                    i_mid_empty,
    output logic                    o_mid_pop,
    input  atd_pkg::t_mid_ctl       i_mid_ctl,
    input  logic [4*STATE_BITS-1:0] i_mid_state,
    output logic                    o_out_push,
    input  logic                    i_out_full,
    output atd_pkg::t_out_word      o_out_word
);

    localparam int GB  = atd_pkg::G_BITS;
    localparam int CB  = atd_pkg::COEFF_BITS;
    localparam int MB  = atd_pkg::MAG_BITS;
    localparam int TW  = CB + GB;
    localparam int TSW = TW - atd_pkg::COEFF_FRAC;
    localparam int UW  = GB + TSW;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_SUM,
        BK_EMIT
    } t_state;

    t_state                r_state;
    logic                  r_prev;
    logic signed [GB-1:0]  r_g1  [2];
    logic signed [GB-1:0]  r_g2  [2];
    logic signed [2*GB-1:0] r_a  [2];
    logic signed [2*GB-1:0] r_b  [2];
    logic signed [TW-1:0]  r_t   [2];
    logic signed [UW-1:0]  r_u   [2];
    logic signed [MB-1:0]  r_mag [2];

    logic signed [CB-1:0]  coeff [2];
    logic signed [GB-1:0]  g1_in [2];
    logic signed [GB-1:0]  g2_in [2];
    logic signed [TSW-1:0] t_sh  [2];
    logic                  tone;

    assign coeff[0] = $signed(i_cfg.mark_coeff);
    assign coeff[1] = $signed(i_cfg.space_coeff);

    // Taking the top G bits is the arithmetic shift of each state.
    assign g1_in[0] = i_mid_state[4*STATE_BITS-1 -: GB];
    assign g2_in[0] = i_mid_state[3*STATE_BITS-1 -: GB];
    assign g1_in[1] = i_mid_state[2*STATE_BITS-1 -: GB];
    assign g2_in[1] = i_mid_state[STATE_BITS-1 -: GB];

    assign t_sh[0] = r_t[0][TW-1:atd_pkg::COEFF_FRAC];
    assign t_sh[1] = r_t[1][TW-1:atd_pkg::COEFF_FRAC];

    assign tone       = (r_mag[0] > r_mag[1]);
    assign o_mid_pop  = (r_state == BK_IDLE) && !i_mid_empty;
    assign o_out_push = (r_state == BK_EMIT) && !i_out_full;
    assign o_out_word = '{bit_res: (tone == r_prev), tone: tone};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_prev  <= 1'b1;
        end else begin
            unique case (r_state)
                BK_IDLE: begin
                    if (o_mid_pop) begin
                        if (i_mid_ctl.restart) begin
                            r_prev <= 1'b1;
                        end
                        for (int l = 0; l < 2; l++) begin
                            r_g1[l] <= g1_in[l];
                            r_g2[l] <= g2_in[l];
                        end
                        if (i_mid_ctl.has_res) begin
                            r_state <= BK_MUL1;
                        end
                    end
                end
                BK_MUL1: begin
                    for (int l = 0; l < 2; l++) begin
                        r_a[l] <= r_g1[l] * r_g1[l];
                        r_t[l] <= coeff[l] * r_g1[l];
                    end
                    r_state <= BK_MUL2;
                end
                BK_MUL2: begin
                    for (int l = 0; l < 2; l++) begin
                        r_b[l] <= r_g2[l] * r_g2[l];
                        r_u[l] <= r_g2[l] * t_sh[l];
                    end
                    r_state <= BK_SUM;
                end
                BK_SUM: begin
                    for (int l = 0; l < 2; l++) begin
                        r_mag[l] <= MB'(r_a[l]) + MB'(r_b[l]) - MB'(r_u[l]);
                    end
                    r_state <= BK_EMIT;
                end
                BK_EMIT: begin
                    if (!i_out_full) begin
                        r_prev  <= tone;
                        r_state <= BK_IDLE;
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/afsk_tone_detector_nrzi_unit.sv =====
// Top level of the AFSK tone detector with NRZI output: registers, front, back, queues.
// Depends on atd_pkg, atd_fifo, atd_front and atd_back.
//
//   channel   direction  handshake         word
//   samples   in         push / full       i_word  (sample, first)
//   results   out        pop / empty       o_word  (bit_res, tone)
//   config    in         i_cfg_we          i_cfg_idx, i_cfg_data
//
// A sample inside a symbol window goes through the phase, low-product, high-product,
// sum and update states of the front end, then the push state when it closes a window
// or carries the first flag; a sample outside any window goes through the phase state
// only. The two-step split of each filter multiply and the single filter lane per
// tone set these steps. The first sample after reset or after a write to either rate
// register first passes a reduction state, one remainder bit per cycle, to reduce the
// phase and the symbol step modulo the sample rate. Reset is synchronous; there is no
// clearing pass. The back end takes each result through two multiply states, a sum
// state and an emit state, so it keeps pace with the front end; two-entry queues let
// either side stall without stopping the other.
module afsk_tone_detector_nrzi_unit #(
    parameter int STATE_BITS = atd_pkg::STATE_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [atd_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [atd_pkg::CFG_DATA_BITS-1:0]     i_cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  atd_pkg::t_in_word                     i_word,
    output logic                                  empty,
    input  logic                                  pop,
    output atd_pkg::t_out_word                    o_word
);

    localparam int CTL_W = $bits(atd_pkg::t_mid_ctl);
    localparam int MID_W = CTL_W + 4 * STATE_BITS;
    localparam int OUT_W = $bits(atd_pkg::t_out_word);

    atd_pkg::t_cfg          r_cfg;
    logic                   rate_wr;

    logic                    mid_push;
    logic                    mid_full;
    logic                    mid_pop;
    logic                    mid_empty;
    atd_pkg::t_mid_ctl       front_ctl;
    logic [4*STATE_BITS-1:0] front_state;
    logic [MID_W-1:0]        mid_rdata;
    atd_pkg::t_mid_ctl       back_ctl;

    logic                    out_push;
    logic                    out_full;
    atd_pkg::t_out_word      back_word;
    logic [OUT_W-1:0]        out_rdata;

    // Configuration registers. Only the low bits of the data word that a
    // register holds are kept; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mark_coeff    <= atd_pkg::MARK_COEFF_RST;
            r_cfg.space_coeff   <= atd_pkg::SPACE_COEFF_RST;
            r_cfg.window_length <= atd_pkg::WINDOW_LENGTH_RST;
            r_cfg.sample_rate   <= atd_pkg::SAMPLE_RATE_RST;
            r_cfg.baud_rate     <= atd_pkg::BAUD_RATE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                atd_pkg::REG_MARK_COEFF: begin
                    r_cfg.mark_coeff <= i_cfg_data[atd_pkg::COEFF_BITS-1:0];
                end
                atd_pkg::REG_SPACE_COEFF: begin
                    r_cfg.space_coeff <= i_cfg_data[atd_pkg::COEFF_BITS-1:0];
                end
                atd_pkg::REG_WINDOW_LENGTH: begin
                    r_cfg.window_length <= i_cfg_data[atd_pkg::WLEN_BITS-1:0];
                end
                atd_pkg::REG_SAMPLE_RATE: begin
                    r_cfg.sample_rate <= i_cfg_data[atd_pkg::RATE_BITS-1:0];
                end
                atd_pkg::REG_BAUD_RATE: begin
                    r_cfg.baud_rate <= i_cfg_data[atd_pkg::RATE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A rate change invalidates the reduced phase and the cached symbol step.
    assign rate_wr = i_cfg_we && ((i_cfg_idx == atd_pkg::REG_SAMPLE_RATE) ||
                                  (i_cfg_idx == atd_pkg::REG_BAUD_RATE));

    atd_front #(
        .STATE_BITS (STATE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_rate_wr   (rate_wr),
        .i_push      (push),
        .o_full      (full),
        .i_word      (i_word),
        .o_mid_push  (mid_push),
        .i_mid_full  (mid_full),
        .o_mid_ctl   (front_ctl),
        .o_mid_state (front_state)
    );

    // Each entry carries either a finished window, a restart of the previous
    // tone, or both, so that the restart is seen in the right order.
    atd_fifo #(
        .WIDTH (MID_W),
        .DEPTH (atd_pkg::MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata ({front_ctl, front_state}),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty)
    );

    assign back_ctl = atd_pkg::t_mid_ctl'(mid_rdata[MID_W-1 -: CTL_W]);

    atd_back #(
        .STATE_BITS (STATE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mid_empty (mid_empty),
        .o_mid_pop   (mid_pop),
        .i_mid_ctl   (back_ctl),
        .i_mid_state (mid_rdata[4*STATE_BITS-1:0]),
        .o_out_push  (out_push),
        .i_out_full  (out_full),
        .o_out_word  (back_word)
    );

    // The result queue holds finished words while the consumer stalls.
    atd_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (atd_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (back_word),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (out_rdata),
        .o_empty (empty)
    );

    assign o_word = atd_pkg::t_out_word'(out_rdata);

endmodule

// ===== src/atd_checker.sv =====
// Port-level checks for the AFSK tone detector, attached to the top level by bind.
// Depends on atd_pkg and on afsk_tone_detector_nrzi_unit.
module atd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_push,
    input logic               i_full,
    input atd_pkg::t_in_word  i_in_word,
    input logic               i_empty,
    input logic               i_pop,
    input atd_pkg::t_out_word i_out_word
);

    // After reset the block is ready for a sample and holds no result.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_full && i_empty))
        else $error("block not clean after reset");

    // The front end is busy for at least the cycle after it takes a sample.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_full) |=> i_full)
        else $error("sample taken without the front end going busy");

    // A first-flagged sample always posts a restart, so it keeps the front busy longer.
    a_first_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_full && i_in_word.first) |=> (i_full ##1 i_full))
        else $error("restart sample finished too early");

    // A waiting result stays put until it is taken.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_empty && !i_pop) |=> (!i_empty && $stable(i_out_word)))
        else $error("waiting result changed or vanished");

endmodule

bind afsk_tone_detector_nrzi_unit atd_checker u_atd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_push     (push),
    .i_full     (full),
    .i_in_word  (i_word),
    .i_empty    (empty),
    .i_pop      (pop),
    .i_out_word (o_word)
);
